>>> hw/rtl/brq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring queue package
// Shared constants, operation codes and the store control group.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int SIZE_CAP      = 256;
  localparam int FUNC_W        = 3;
  localparam int BYTE_W        = 8;
  localparam int CNT_PORT_W    = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_PEEK   = 3'd2,
    FUNC_REWIND = 3'd3,
    FUNC_COMMIT = 3'd4,
    FUNC_SETOFF = 3'd5,
    FUNC_STATUS = 3'd6
  } func_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage : brq_pkg
`default_nettype wire

>>> hw/rtl/brq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring queue store
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brq_mem #(
  parameter int DEPTH = brq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire brq_pkg::mem_ctl_t          ctl,
  input  wire logic [$clog2((DEPTH < brq_pkg::SIZE_CAP) ? DEPTH : brq_pkg::SIZE_CAP)-1:0] wr_addr,
  input  wire logic [$clog2((DEPTH < brq_pkg::SIZE_CAP) ? DEPTH : brq_pkg::SIZE_CAP)-1:0] rd_addr,
  input  wire logic [brq_pkg::BYTE_W-1:0] wr_data,
  output logic      [brq_pkg::BYTE_W-1:0] rd_data
);
  import brq_pkg::*;

  localparam int CAP = (DEPTH < SIZE_CAP) ? DEPTH : SIZE_CAP;

  logic [BYTE_W-1:0] mem [CAP];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : brq_mem
`default_nettype wire

>>> hw/rtl/brq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring queue control
// Holds the cursors, counts and slot count, decodes one operation per
// transaction and derives the status fields from the updated state.
// ----------------------------------------------------------------------------
module brq_ctrl #(
  parameter int DEPTH = brq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [brq_pkg::FUNC_W-1:0]     func,
  input  wire logic [brq_pkg::BYTE_W-1:0]     data_in,
  input  wire logic [brq_pkg::CNT_PORT_W-1:0] peek_offset,
  input  wire logic                           cfg_we,
  input  wire logic [brq_pkg::CNT_PORT_W-1:0] cfg_data,
  output brq_pkg::mem_ctl_t                   mem_ctl,
  output logic [$clog2((DEPTH < brq_pkg::SIZE_CAP) ? DEPTH : brq_pkg::SIZE_CAP)-1:0] wr_addr,
  output logic [$clog2((DEPTH < brq_pkg::SIZE_CAP) ? DEPTH : brq_pkg::SIZE_CAP)-1:0] rd_addr,
  output logic [brq_pkg::BYTE_W-1:0]          wr_data,
  output logic                                op_ok,
  output logic                                rd_hit,
  output logic [brq_pkg::CNT_PORT_W-1:0]      count,
  output logic [brq_pkg::CNT_PORT_W-1:0]      free_space,
  output logic [brq_pkg::CNT_PORT_W-1:0]      peek_remaining,
  output logic [brq_pkg::CNT_PORT_W-1:0]      peek_position,
  output logic                                is_empty,
  output logic                                peek_exhausted
);
  import brq_pkg::*;

  localparam int CAP   = (DEPTH < SIZE_CAP) ? DEPTH : SIZE_CAP;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  logic [CNT_W-1:0] size;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [IDX_W-1:0] peek, peek_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] left, left_next;
  logic             ok_next;
  logic             rd_next;
  logic [CNT_W:0]   pos;
  logic [CNT_W-1:0] size_wr;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] slots);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= slots) ? '0 : inc[IDX_W-1:0];
  endfunction

  always_comb begin
    if (cfg_data == '0) begin
      size_wr = CNT_W'(1);
    end else if (cfg_data > CNT_PORT_W'(CAP)) begin
      size_wr = CNT_W'(CAP);
    end else begin
      size_wr = cfg_data[CNT_W-1:0];
    end
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    peek_next = peek;
    fill_next = fill;
    left_next = left;
    ok_next   = 1'b0;
    rd_next   = 1'b0;
    mem_ctl   = '0;
    rd_addr   = peek;
    pos       = (CNT_W+1)'(head) + (CNT_W+1)'(peek_offset[CNT_W-1:0]);
    if (pos >= (CNT_W+1)'(size)) begin
      pos = pos - (CNT_W+1)'(size);
    end
    unique case (func_t'(func))
      FUNC_PUSH: begin
        if (fill < size) begin
          mem_ctl.wr_en = accept;
          tail_next     = advance(tail, size);
          fill_next     = fill + CNT_W'(1);
          left_next     = left + CNT_W'(1);
          ok_next       = 1'b1;
        end
      end
      FUNC_POP: begin
        rd_addr = head;
        if (fill != '0) begin
          mem_ctl.rd_en = accept;
          head_next     = advance(head, size);
          peek_next     = head_next;
          fill_next     = fill - CNT_W'(1);
          left_next     = fill - CNT_W'(1);
          ok_next       = 1'b1;
          rd_next       = 1'b1;
        end
      end
      FUNC_PEEK: begin
        if (left != '0) begin
          mem_ctl.rd_en = accept;
          peek_next     = advance(peek, size);
          left_next     = left - CNT_W'(1);
          ok_next       = 1'b1;
          rd_next       = 1'b1;
        end
      end
      FUNC_REWIND: begin
        peek_next = head;
        left_next = fill;
        ok_next   = 1'b1;
      end
      FUNC_COMMIT: begin
        head_next = peek;
        fill_next = left;
        ok_next   = 1'b1;
      end
      FUNC_SETOFF: begin
        if (peek_offset <= CNT_PORT_W'(fill)) begin
          peek_next = pos[IDX_W-1:0];
          left_next = fill - peek_offset[CNT_W-1:0];
          ok_next   = 1'b1;
        end
      end
      FUNC_STATUS: begin
        ok_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = tail;
  assign wr_data = data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      size   <= CNT_W'(CAP);
      head   <= '0;
      tail   <= '0;
      peek   <= '0;
      fill   <= '0;
      left   <= '0;
      op_ok  <= 1'b0;
      rd_hit <= 1'b0;
    end else if (cfg_we) begin
      size <= size_wr;
      head <= '0;
      tail <= '0;
      peek <= '0;
      fill <= '0;
      left <= '0;
    end else if (accept) begin
      head   <= head_next;
      tail   <= tail_next;
      peek   <= peek_next;
      fill   <= fill_next;
      left   <= left_next;
      op_ok  <= ok_next;
      rd_hit <= rd_next;
    end
  end

  assign count          = CNT_PORT_W'(fill);
  assign free_space     = CNT_PORT_W'(size - fill);
  assign peek_remaining = CNT_PORT_W'(left);
  assign peek_position  = CNT_PORT_W'(fill - left);
  assign is_empty       = (fill == '0);
  assign peek_exhausted = (left == '0);

endmodule : brq_ctrl
`default_nettype wire

>>> hw/rtl/byte_ring_queue_with_peek.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring queue with peek cursor
// A transaction's result is registered, valid in the cycle after acceptance.
// Throughput: one operation per cycle unless the output stalls, set by the
// single store read port and the cursor update done in the accepting cycle.
// Reset: cursors and counts clear, slot count returns to its maximum, and
// the store contents are left undefined until written.
// ----------------------------------------------------------------------------
module byte_ring_queue_with_peek #(
  parameter int DEPTH = brq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [brq_pkg::FUNC_W-1:0]     func,
  input  wire logic [brq_pkg::BYTE_W-1:0]     data_in,
  input  wire logic [brq_pkg::CNT_PORT_W-1:0] peek_offset,
  input  wire logic                           buffer_size_we,
  input  wire logic [brq_pkg::CNT_PORT_W-1:0] buffer_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [brq_pkg::BYTE_W-1:0]          data_out,
  output logic                                ok,
  output logic [brq_pkg::CNT_PORT_W-1:0]      count,
  output logic [brq_pkg::CNT_PORT_W-1:0]      free_space,
  output logic [brq_pkg::CNT_PORT_W-1:0]      peek_remaining,
  output logic [brq_pkg::CNT_PORT_W-1:0]      peek_position,
  output logic                                is_empty,
  output logic                                peek_exhausted
);
  import brq_pkg::*;

  localparam int CAP   = (DEPTH < SIZE_CAP) ? DEPTH : SIZE_CAP;
  localparam int IDX_W = $clog2(CAP);

  logic              accept;
  logic              rd_hit;
  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rd_data;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  brq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (func),
    .data_in        (data_in),
    .peek_offset    (peek_offset),
    .cfg_we         (buffer_size_we),
    .cfg_data       (buffer_size),
    .mem_ctl        (mem_ctl),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .wr_data        (wr_data),
    .op_ok          (ok),
    .rd_hit         (rd_hit),
    .count          (count),
    .free_space     (free_space),
    .peek_remaining (peek_remaining),
    .peek_position  (peek_position),
    .is_empty       (is_empty),
    .peek_exhausted (peek_exhausted)
  );

  brq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign data_out = rd_hit ? rd_data : '0;

endmodule : byte_ring_queue_with_peek
`default_nettype wire
